/* design/assert_macros.svh */
// Assertion macros used by the slot allocator design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("slot allocator check failed");
// Check a property on every clock edge, reset included.
`define SA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("slot allocator check failed");
`else
`define SA_ASSERT(label, prop)
`define SA_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* design/slot_alloc_pkg.sv */
// Types, codes and helpers of the slot allocator.
package slot_alloc_pkg;

  localparam int unsigned SLOTS = 256;
  localparam int ID_W  = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam id_t NONE_ID = ID_W'(SLOTS);

  // Register index of the slot count register
  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_W1,
    ST_W2,
    ST_W3
  } state_t;

  typedef struct packed {
    op_t operation;
    id_t slot_id;
  } req_t;

  typedef struct packed {
    status_t status;
    id_t     granted_slot;
    id_t     in_use_count;
  } rsp_t;

  // A link value at or above the slot count of the store means none
  function automatic logic is_slot(id_t v);
    return v < NONE_ID;
  endfunction

endpackage

/* design/slot_allocator_free_used_lists.sv */
// Slot allocator keeping free and used doubly linked lists in two link memories.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  req     | in        | req_valid / req_stall      | operation, slot_id
//  rsp     | out       | rsp_valid / rsp_stall      | status, granted_slot, in_use_count
//  apb     | in        | psel, penable, pwrite      | paddr, pwdata, prdata (slot_count)
//
//  Each request passes through the states W1, W2 and W3 from its transfer to the result register,
//  and the next request is taken in the cycle that result is loaded, so a new request is not taken
//  before the last one is through; this is set by the prev_link memory, which takes up to three
//  writes per request on its single write port. Reset and every slot_count write start a sweep
//  over all SLOTS (256) entries that rewrites both link memories; requests are stalled during the
//  sweep. A result left waiting in the output register holds only the completion of the request behind it.
`include "assert_macros.svh"

module slot_allocator_free_used_lists (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  slot_alloc_pkg::req_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output slot_alloc_pkg::rsp_t  rsp
);

  localparam int ID_W  = slot_alloc_pkg::ID_W;
  localparam int IDX_W = slot_alloc_pkg::IDX_W;

  slot_alloc_pkg::state_t state, state_next;

  // List registers
  slot_alloc_pkg::idx_t sweep_idx;
  slot_alloc_pkg::id_t  slot_count;
  slot_alloc_pkg::id_t  free_head;
  slot_alloc_pkg::id_t  used_head;
  slot_alloc_pkg::id_t  used_total;

  // Request in flight
  slot_alloc_pkg::op_t     job_op;
  slot_alloc_pkg::id_t     job_id;
  slot_alloc_pkg::status_t job_status;
  slot_alloc_pkg::id_t     job_granted;
  slot_alloc_pkg::id_t     job_old;
  logic                    job_work;

  // Bypass of a prev_link write that lands with the read of the next request
  logic                fwd_hit;
  slot_alloc_pkg::id_t fwd_data;

  // Link memories
  logic [ID_W-1:0] next_mem [slot_alloc_pkg::SLOTS];
  logic [ID_W-1:0] prev_mem [slot_alloc_pkg::SLOTS];
  slot_alloc_pkg::id_t next_q, prev_q, prev_rd;

  logic                 rd_en;
  slot_alloc_pkg::idx_t rd_addr;
  logic                 next_we, prev_we;
  slot_alloc_pkg::idx_t next_waddr, prev_waddr;
  slot_alloc_pkg::id_t  next_wdata, prev_wdata;

  logic                    accept, out_free, cfg_wr;
  slot_alloc_pkg::id_t     cfg_value;
  slot_alloc_pkg::status_t acc_status;
  slot_alloc_pkg::id_t     acc_id, acc_granted;
  slot_alloc_pkg::id_t     sweep_ext;
  logic                    sweep_in;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == slot_alloc_pkg::REG_SLOT_COUNT);
  assign cfg_value = (pwdata[ID_W-1:0] > slot_alloc_pkg::NONE_ID) ?
                     slot_alloc_pkg::NONE_ID : pwdata[ID_W-1:0];
  assign prdata = (paddr[2] == slot_alloc_pkg::REG_SLOT_COUNT) ?
                  {{(32-ID_W){1'b0}}, slot_count} : 32'd0;

  assign out_free = !rsp_valid || !rsp_stall;
  assign accept   = req_valid && !req_stall;
  assign job_work = (job_status == slot_alloc_pkg::STAT_OK);
  assign prev_rd  = fwd_hit ? fwd_data : prev_q;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      slot_alloc_pkg::ST_SWEEP: begin
        if (sweep_idx == IDX_W'(slot_alloc_pkg::SLOTS - 1)) state_next = slot_alloc_pkg::ST_IDLE;
      end
      slot_alloc_pkg::ST_IDLE: begin
        if (accept) state_next = slot_alloc_pkg::ST_W1;
      end
      slot_alloc_pkg::ST_W1: state_next = slot_alloc_pkg::ST_W2;
      slot_alloc_pkg::ST_W2: state_next = slot_alloc_pkg::ST_W3;
      slot_alloc_pkg::ST_W3: begin
        if (out_free) state_next = accept ? slot_alloc_pkg::ST_W1 : slot_alloc_pkg::ST_IDLE;
      end
      default: state_next = slot_alloc_pkg::ST_IDLE;
    endcase
    if (cfg_wr) state_next = slot_alloc_pkg::ST_SWEEP;
  end

  // Classify the incoming request
  always_comb begin
    acc_status  = slot_alloc_pkg::STAT_OK;
    acc_granted = slot_alloc_pkg::NONE_ID;
    acc_id      = req.slot_id;
    if (req.operation == slot_alloc_pkg::OP_ALLOC) begin
      acc_id = free_head;
      if (slot_alloc_pkg::is_slot(free_head)) begin
        acc_granted = free_head;
      end else begin
        acc_status = slot_alloc_pkg::STAT_EMPTY;
      end
    end else if (req.slot_id == slot_alloc_pkg::NONE_ID) begin
      acc_status = slot_alloc_pkg::STAT_INVALID;
    end else if (req.slot_id >= slot_count || !slot_alloc_pkg::is_slot(req.slot_id)) begin
      acc_status = slot_alloc_pkg::STAT_RANGE;
    end
  end

  // Rebuild values of the sweep entry
  assign sweep_ext = ID_W'(sweep_idx);
  assign sweep_in  = sweep_ext < slot_count;

  // Handshake and memory port control
  always_comb begin
    req_stall  = !((state == slot_alloc_pkg::ST_IDLE)
                   || ((state == slot_alloc_pkg::ST_W3) && out_free));
    rd_en      = accept;
    rd_addr    = (req.operation == slot_alloc_pkg::OP_ALLOC) ?
                 free_head[IDX_W-1:0] : req.slot_id[IDX_W-1:0];
    next_we    = 1'b0;
    next_waddr = job_id[IDX_W-1:0];
    next_wdata = slot_alloc_pkg::NONE_ID;
    prev_we    = 1'b0;
    prev_waddr = job_id[IDX_W-1:0];
    prev_wdata = slot_alloc_pkg::NONE_ID;
    case (state)
      slot_alloc_pkg::ST_SWEEP: begin
        next_we    = 1'b1;
        next_waddr = sweep_idx;
        next_wdata = (sweep_in && (ID_W'(sweep_ext + 1'b1) < slot_count)) ?
                     ID_W'(sweep_ext + 1'b1) : slot_alloc_pkg::NONE_ID;
        prev_we    = 1'b1;
        prev_waddr = sweep_idx;
        prev_wdata = (sweep_in && (sweep_idx != '0)) ?
                     ID_W'(sweep_ext - 1'b1) : slot_alloc_pkg::NONE_ID;
      end
      slot_alloc_pkg::ST_W1: begin
        // Unlink: detach the successor of the popped slot, or splice around the freed slot
        prev_we    = job_work && slot_alloc_pkg::is_slot(next_q);
        prev_waddr = next_q[IDX_W-1:0];
        if (job_op == slot_alloc_pkg::OP_FREE) begin
          prev_wdata = prev_rd;
          next_we    = job_work && slot_alloc_pkg::is_slot(prev_rd);
          next_waddr = prev_rd[IDX_W-1:0];
          next_wdata = next_q;
        end
      end
      slot_alloc_pkg::ST_W2: begin
        // Push the slot onto the front of its new list
        prev_we    = job_work;
        next_we    = job_work;
        next_wdata = job_old;
      end
      slot_alloc_pkg::ST_W3: begin
        // Point the old list head back at the slot
        prev_we    = job_work && slot_alloc_pkg::is_slot(job_old);
        prev_waddr = job_old[IDX_W-1:0];
        prev_wdata = job_id;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= slot_alloc_pkg::ST_SWEEP;
      sweep_idx  <= '0;
      slot_count <= slot_alloc_pkg::NONE_ID;
      free_head  <= '0;
      used_head  <= slot_alloc_pkg::NONE_ID;
      used_total <= '0;
      rsp_valid  <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        sweep_idx <= '0;
      end else if (state == slot_alloc_pkg::ST_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (cfg_wr) begin
        slot_count <= cfg_value;
        free_head  <= (cfg_value == '0) ? slot_alloc_pkg::NONE_ID : '0;
        used_head  <= slot_alloc_pkg::NONE_ID;
        used_total <= '0;
      end else if ((state == slot_alloc_pkg::ST_W1) && job_work) begin
        if (job_op == slot_alloc_pkg::OP_ALLOC) begin
          free_head  <= next_q;
          used_head  <= job_id;
          used_total <= used_total + 1'b1;
        end else begin
          if (used_head == job_id) used_head <= next_q;
          free_head  <= job_id;
          used_total <= used_total - 1'b1;
        end
      end
      if ((state == slot_alloc_pkg::ST_W3) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept) fwd_hit <= prev_we && (prev_waddr == rd_addr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      job_op      <= req.operation;
      job_id      <= acc_id;
      job_status  <= acc_status;
      job_granted <= acc_granted;
      fwd_data    <= prev_wdata;
    end
    if (state == slot_alloc_pkg::ST_W1) begin
      job_old <= (job_op == slot_alloc_pkg::OP_ALLOC) ? used_head : free_head;
    end
    if ((state == slot_alloc_pkg::ST_W3) && out_free) begin
      rsp.status       <= job_status;
      rsp.granted_slot <= job_granted;
      rsp.in_use_count <= used_total;
    end
  end

  // next_link memory
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (rd_en) next_q <= next_mem[rd_addr];
  end

  // prev_link memory
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (rd_en) prev_q <= prev_mem[rd_addr];
  end

  // A new result is loaded only as a request completes
  `SA_ASSERT(a_rsp_from_w3, $rose(rsp_valid) |-> $past(state == slot_alloc_pkg::ST_W3))
  // The in-use count moves only in the unlink cycle or on a rebuild
  `SA_ASSERT(a_total_moves, !$stable(used_total) |-> ($past(state == slot_alloc_pkg::ST_W1) || $past(cfg_wr)))
  // Only a successful allocate names a slot
  `SA_ASSERT(a_grant_ok, (rsp_valid && (rsp.status != slot_alloc_pkg::STAT_OK)) |-> (rsp.granted_slot == slot_alloc_pkg::NONE_ID))
  // The bypass is used only behind a request that completed in the same cycle
  `SA_ASSERT(a_fwd_origin, (fwd_hit && (state == slot_alloc_pkg::ST_W1)) |-> $past(state == slot_alloc_pkg::ST_W3))

endmodule

/* tb/tb_top.sv */
// Testbench for the slot allocator: linked-list predictor, scoreboard and APB/request drivers.
`timescale 1ns / 1ps

// Tracks the free and used lists and checks each response against its prediction
class slot_list_scoreboard;
  slot_alloc_pkg::id_t fwd_link [slot_alloc_pkg::SLOTS];
  slot_alloc_pkg::id_t back_link [slot_alloc_pkg::SLOTS];
  slot_alloc_pkg::id_t free_head;
  slot_alloc_pkg::id_t used_head;
  slot_alloc_pkg::id_t used_total;
  slot_alloc_pkg::id_t slot_limit;
  slot_alloc_pkg::rsp_t expected_q[$];
  int unsigned errors;

  function new();
    errors = 0;
    slot_limit = slot_alloc_pkg::NONE_ID;
    rebuild();
  endfunction

  function bit linked(slot_alloc_pkg::id_t v);
    return v < slot_alloc_pkg::NONE_ID;
  endfunction

  // Chain 0..n-1 onto the free list, empty the used list
  function void rebuild();
    for (int i = 0; i < slot_alloc_pkg::SLOTS; i++) begin
      if (i < slot_limit) begin
        back_link[i] = (i == 0) ? slot_alloc_pkg::NONE_ID : slot_alloc_pkg::id_t'(i - 1);
        fwd_link[i]  = (i + 1 < slot_limit) ? slot_alloc_pkg::id_t'(i + 1) :
                       slot_alloc_pkg::NONE_ID;
      end else begin
        back_link[i] = slot_alloc_pkg::NONE_ID;
        fwd_link[i]  = slot_alloc_pkg::NONE_ID;
      end
    end
    free_head  = (slot_limit == 0) ? slot_alloc_pkg::NONE_ID : slot_alloc_pkg::id_t'(0);
    used_head  = slot_alloc_pkg::NONE_ID;
    used_total = '0;
  endfunction

  // Apply an APB write; unknown registers are ignored, slot count saturates
  function void write_register(int idx, logic [31:0] value);
    slot_alloc_pkg::id_t v;
    if (idx != int'(slot_alloc_pkg::REG_SLOT_COUNT)) return;
    v = value[8:0];
    if (v > slot_alloc_pkg::NONE_ID) v = slot_alloc_pkg::NONE_ID;
    slot_limit = v;
    rebuild();
  endfunction

  // Advance the lists for one accepted request and queue the response it yields
  function slot_alloc_pkg::rsp_t note_request(slot_alloc_pkg::req_t r);
    slot_alloc_pkg::status_t st;
    slot_alloc_pkg::id_t granted;
    slot_alloc_pkg::id_t s;
    slot_alloc_pkg::id_t p;
    slot_alloc_pkg::id_t n;
    slot_alloc_pkg::id_t prior_head;
    slot_alloc_pkg::rsp_t e;
    st = slot_alloc_pkg::STAT_OK;
    granted = slot_alloc_pkg::NONE_ID;
    if (r.operation == slot_alloc_pkg::OP_ALLOC) begin
      if (!linked(free_head)) begin
        st = slot_alloc_pkg::STAT_EMPTY;
      end else begin
        s = free_head;
        free_head = fwd_link[s[7:0]];
        if (linked(fwd_link[s[7:0]]))
          back_link[fwd_link[s[7:0]][7:0]] = slot_alloc_pkg::NONE_ID;
        prior_head = used_head;
        used_head = s;
        back_link[s[7:0]] = slot_alloc_pkg::NONE_ID;
        fwd_link[s[7:0]] = prior_head;
        if (linked(prior_head)) back_link[prior_head[7:0]] = s;
        used_total = used_total + 1'b1;
        granted = s;
      end
    end else begin
      if (r.slot_id == slot_alloc_pkg::NONE_ID) begin
        st = slot_alloc_pkg::STAT_INVALID;
      end else if (r.slot_id >= slot_limit || !linked(r.slot_id)) begin
        st = slot_alloc_pkg::STAT_RANGE;
      end else begin
        s = r.slot_id;
        p = back_link[s[7:0]];
        n = fwd_link[s[7:0]];
        if (linked(p)) fwd_link[p[7:0]] = fwd_link[s[7:0]];
        if (linked(n)) back_link[n[7:0]] = back_link[s[7:0]];
        if (used_head == s) used_head = fwd_link[s[7:0]];
        prior_head = free_head;
        back_link[s[7:0]] = slot_alloc_pkg::NONE_ID;
        fwd_link[s[7:0]] = free_head;
        free_head = s;
        if (linked(prior_head)) back_link[prior_head[7:0]] = s;
        used_total = used_total - 1'b1;
      end
    end
    e.status = st;
    e.granted_slot = granted;
    e.in_use_count = used_total;
    expected_q.push_back(e);
    return e;
  endfunction

  // Compare one response with the oldest prediction
  function void check_result(slot_alloc_pkg::rsp_t got);
    slot_alloc_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected response: status %0d granted %0d in_use %0d",
                 got.status, got.granted_slot, got.in_use_count);
      return;
    end
    e = expected_q.pop_front();
    if (got.status !== e.status || got.granted_slot !== e.granted_slot ||
        got.in_use_count !== e.in_use_count) begin
      errors++;
      if (errors <= 10)
        $display("response mismatch: exp status %0d granted %0d in_use %0d, got %0d %0d %0d",
                 e.status, e.granted_slot, e.in_use_count,
                 got.status, got.granted_slot, got.in_use_count);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Register index with no register behind it
  localparam int UNUSED_REG_IDX = 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_stall;
  slot_alloc_pkg::req_t req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  slot_alloc_pkg::rsp_t rsp;

  bit quiet = 1'b0;
  int unsigned cycles = 0;
  int live_q[$];
  slot_list_scoreboard sb = new();

  slot_allocator_free_used_lists i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the response side at random, except in quiet stretches
  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // Present one request, idling at random first, and hold it until transfer
  task automatic send_request(slot_alloc_pkg::op_t op, slot_alloc_pkg::id_t id);
    slot_alloc_pkg::req_t r;
    slot_alloc_pkg::rsp_t e;
    int k;
    r.operation = op;
    r.slot_id = id;
    while (!quiet && $urandom_range(0, 99) < 7) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    e = sb.note_request(r);
    // Track which slots are handed out so frees can target them
    if (e.status == slot_alloc_pkg::STAT_OK) begin
      if (op == slot_alloc_pkg::OP_ALLOC) begin
        live_q.push_back(int'(e.granted_slot));
      end else begin
        k = -1;
        foreach (live_q[j]) if (live_q[j] == int'(id)) k = j;
        if (k >= 0) live_q.delete(k);
      end
    end
  endtask

  // Drop valid and wait until every response has come, plus drain time
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(int idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_register(idx, value);
    if (idx == int'(slot_alloc_pkg::REG_SLOT_COUNT)) live_q.delete();
  endtask

  // Mostly frees of handed-out slots and allocates; some invalid, out-of-range, stray frees
  task automatic random_item();
    int r;
    int k;
    int lim;
    r = $urandom_range(0, 99);
    lim = int'(sb.slot_limit);
    if (r < 50 || (r < 88 && live_q.size() == 0)) begin
      send_request(slot_alloc_pkg::OP_ALLOC,
                   slot_alloc_pkg::id_t'($urandom_range(0, slot_alloc_pkg::SLOTS)));
    end else if (r < 88) begin
      k = $urandom_range(0, live_q.size() - 1);
      send_request(slot_alloc_pkg::OP_FREE, slot_alloc_pkg::id_t'(live_q[k]));
    end else if (r < 92) begin
      send_request(slot_alloc_pkg::OP_FREE, slot_alloc_pkg::NONE_ID);
    end else if (r < 96 && lim < slot_alloc_pkg::SLOTS) begin
      send_request(slot_alloc_pkg::OP_FREE,
                   slot_alloc_pkg::id_t'($urandom_range(lim, slot_alloc_pkg::SLOTS - 1)));
    end else begin
      send_request(slot_alloc_pkg::OP_FREE,
                   slot_alloc_pkg::id_t'($urandom_range(0, slot_alloc_pkg::SLOTS - 1)));
    end
  endtask

  initial begin
    logic [31:0] phase_counts[10];
    phase_counts = '{32'd300, 32'd8, 32'd1, 32'd0, 32'h1FF, 32'd5, 32'd64, 32'd2,
                     32'd256, 32'd17};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Full slot range after reset: middle, head and tail unlinks, invalid id
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_ALLOC, 9'd255);
    send_request(slot_alloc_pkg::OP_ALLOC, slot_alloc_pkg::NONE_ID);
    send_request(slot_alloc_pkg::OP_FREE, 9'd1);
    send_request(slot_alloc_pkg::OP_FREE, 9'd2);
    send_request(slot_alloc_pkg::OP_FREE, 9'd0);
    send_request(slot_alloc_pkg::OP_FREE, slot_alloc_pkg::NONE_ID);
    send_request(slot_alloc_pkg::OP_ALLOC, slot_alloc_pkg::NONE_ID);

    // Fill every slot, hit empty, then free both ends, back to back
    quiet = 1'b1;
    repeat (256) send_request(slot_alloc_pkg::OP_ALLOC,
                              slot_alloc_pkg::id_t'($urandom_range(0, slot_alloc_pkg::SLOTS)));
    send_request(slot_alloc_pkg::OP_FREE, 9'd255);
    send_request(slot_alloc_pkg::OP_FREE, 9'd128);
    send_request(slot_alloc_pkg::OP_FREE, 9'd0);
    wait_drained();
    quiet = 1'b0;

    // Two slots: out of range ids, empty list, double free
    write_register(int'(slot_alloc_pkg::REG_SLOT_COUNT), 32'd2);
    send_request(slot_alloc_pkg::OP_FREE, 9'd2);
    send_request(slot_alloc_pkg::OP_FREE, 9'd255);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_FREE, 9'd0);
    send_request(slot_alloc_pkg::OP_FREE, 9'd1);
    send_request(slot_alloc_pkg::OP_FREE, 9'd1);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    wait_drained();

    // No slots at all; an unknown register write must leave that alone
    write_register(int'(slot_alloc_pkg::REG_SLOT_COUNT), 32'd0);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_FREE, 9'd0);
    wait_drained();
    write_register(UNUSED_REG_IDX, 32'd5);
    send_request(slot_alloc_pkg::OP_ALLOC, '0);
    send_request(slot_alloc_pkg::OP_FREE, slot_alloc_pkg::NONE_ID);
    wait_drained();

    // Random phases over several slot counts, saturating writes included
    foreach (phase_counts[ph]) begin
      write_register(int'(slot_alloc_pkg::REG_SLOT_COUNT), phase_counts[ph]);
      quiet = (ph == 6);
      repeat (12) random_item();
      wait_drained();
    end
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
